// File: sv/ltdr_pkg.sv
// Shared types and constants for the LED toggle / dim ramp controller.
// No dependencies; every other file refers to it by scoped names.
package ltdr_pkg;

  // Q1.15 duty where this value is full scale
  localparam logic [15:0] DUTY_ONE = 16'd32768;

  // classified input
  localparam logic [1:0] IN_OFF = 2'd0;
  localparam logic [1:0] IN_ON  = 2'd1;
  localparam logic [1:0] IN_DIM = 2'd2;

  // light state
  localparam logic [1:0] LS_OFF  = 2'd0;
  localparam logic [1:0] LS_ON   = 2'd1;
  localparam logic [1:0] LS_UP   = 2'd2;
  localparam logic [1:0] LS_DOWN = 2'd3;

  // sensor pulse classes
  localparam logic [1:0] PC_HIDDEN = 2'd0;
  localparam logic [1:0] PC_SHORT  = 2'd1;
  localparam logic [1:0] PC_LONG   = 2'd2;

  // configuration register file
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [2:0] REG_PASS_MODE     = 3'd0;
  localparam logic [2:0] REG_INPUT_MAPPING = 3'd1;
  localparam logic [2:0] REG_STEP_UP       = 3'd2;
  localparam logic [2:0] REG_STEP_DOWN     = 3'd3;
  localparam logic [2:0] REG_DUTY_FLOOR    = 3'd4;
  localparam logic [2:0] REG_SAVE_INTERVAL = 3'd5;

  localparam logic [15:0] STEP_UP_RST       = 16'd33;
  localparam logic [15:0] STEP_DOWN_RST     = 16'd33;
  localparam logic [15:0] DUTY_FLOOR_RST    = 16'd2294;
  localparam logic [15:0] SAVE_INTERVAL_RST = 16'd30000;

  typedef struct packed {
    logic        pass_mode;
    logic        input_mapping;
    logic [15:0] step_up;
    logic [15:0] step_down;
    logic [15:0] duty_floor;
    logic [15:0] save_interval;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  prev_input;
    logic [1:0]  light;
    logic [15:0] duty;
    logic [15:0] tick;
  } state_t;

  typedef struct packed {
    logic [1:0]  pulse_class;
    logic [15:0] current_duty;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  light_state;
    logic [15:0] duty_level;
    logic        save_request;
    logic [1:0]  mapped_input;
  } out_item_t;

endpackage

// File: sv/ltdr_in_if.sv
// Input channel: one tick item per beat, valid/ready handshake.
// Depends on ltdr_pkg for the payload type.
interface ltdr_in_if;
  logic               valid;
  logic               ready;
  ltdr_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/ltdr_out_if.sv
// Result channel: one result per beat, valid/ready handshake.
// Depends on ltdr_pkg for the payload type.
interface ltdr_out_if;
  logic                valid;
  logic                ready;
  ltdr_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/ltdr_cfg_regs.sv
// APB-style configuration register file, one register per 32-bit word.
// Depends on ltdr_pkg for register indexes, reset values and cfg_t.
module ltdr_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ltdr_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [ltdr_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [ltdr_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output ltdr_pkg::cfg_t                       cfg_o
);

  ltdr_pkg::cfg_t cfg_q;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[ltdr_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pass_mode     <= 1'b0;
      cfg_q.input_mapping <= 1'b0;
      cfg_q.step_up       <= ltdr_pkg::STEP_UP_RST;
      cfg_q.step_down     <= ltdr_pkg::STEP_DOWN_RST;
      cfg_q.duty_floor    <= ltdr_pkg::DUTY_FLOOR_RST;
      cfg_q.save_interval <= ltdr_pkg::SAVE_INTERVAL_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        ltdr_pkg::REG_PASS_MODE:     cfg_q.pass_mode     <= pwdata[0];
        ltdr_pkg::REG_INPUT_MAPPING: cfg_q.input_mapping <= pwdata[0];
        ltdr_pkg::REG_STEP_UP:       cfg_q.step_up       <= pwdata[15:0];
        ltdr_pkg::REG_STEP_DOWN:     cfg_q.step_down     <= pwdata[15:0];
        ltdr_pkg::REG_DUTY_FLOOR:    cfg_q.duty_floor    <= pwdata[15:0];
        ltdr_pkg::REG_SAVE_INTERVAL: cfg_q.save_interval <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ltdr_pkg::REG_PASS_MODE:     prdata = {31'd0, cfg_q.pass_mode};
      ltdr_pkg::REG_INPUT_MAPPING: prdata = {31'd0, cfg_q.input_mapping};
      ltdr_pkg::REG_STEP_UP:       prdata = {16'd0, cfg_q.step_up};
      ltdr_pkg::REG_STEP_DOWN:     prdata = {16'd0, cfg_q.step_down};
      ltdr_pkg::REG_DUTY_FLOOR:    prdata = {16'd0, cfg_q.duty_floor};
      ltdr_pkg::REG_SAVE_INTERVAL: prdata = {16'd0, cfg_q.save_interval};
      default:                     prdata = '0;
    endcase
  end

endmodule

// File: sv/ltdr_step.sv
// Next-state and result logic for one tick: classify, toggle / ramp, save timer.
// Depends on ltdr_pkg for codes and the cfg_t, state_t and item types.
module ltdr_step (
  input  ltdr_pkg::cfg_t      cfg_i,
  input  ltdr_pkg::state_t    state_i,
  input  ltdr_pkg::in_item_t  item_i,
  output ltdr_pkg::state_t    state_o,
  output ltdr_pkg::out_item_t result_o
);

  always_comb begin
    logic [15:0] cur;
    logic [1:0]  now;
    logic [1:0]  light;
    logic [15:0] duty;
    logic [16:0] up_sum;
    logic [16:0] down_lim;
    logic [15:0] tick_inc;
    logic        save;

    cur = (item_i.current_duty > ltdr_pkg::DUTY_ONE) ? ltdr_pkg::DUTY_ONE
                                                     : item_i.current_duty;

    if (!cfg_i.input_mapping) begin
      if (item_i.pulse_class == ltdr_pkg::PC_SHORT)     now = ltdr_pkg::IN_ON;
      else if (item_i.pulse_class == ltdr_pkg::PC_LONG) now = ltdr_pkg::IN_DIM;
      else                                              now = ltdr_pkg::IN_OFF;
    end else begin
      now = (item_i.pulse_class == ltdr_pkg::PC_HIDDEN) ? ltdr_pkg::IN_ON
                                                        : ltdr_pkg::IN_OFF;
    end

    light = state_i.light;
    duty  = state_i.duty;

    if (cfg_i.pass_mode) begin
      light = (now == ltdr_pkg::IN_OFF) ? ltdr_pkg::LS_ON : ltdr_pkg::LS_OFF;
    end else if (now == ltdr_pkg::IN_OFF && state_i.prev_input == ltdr_pkg::IN_ON) begin
      // falling edge of "on": off turns on, any non-off state (ramps too) turns off
      light = (light == ltdr_pkg::LS_OFF) ? ltdr_pkg::LS_ON : ltdr_pkg::LS_OFF;
    end else if (now == ltdr_pkg::IN_DIM) begin
      if (state_i.prev_input == ltdr_pkg::IN_ON) begin
        light = ltdr_pkg::LS_UP;
        duty  = (cur < cfg_i.duty_floor) ? cfg_i.duty_floor : cur;
      end
    end

    // ramp step applies in the same tick as ramp entry
    up_sum   = {1'b0, duty} + {1'b0, cfg_i.step_up};
    down_lim = {1'b0, cfg_i.duty_floor} + {1'b0, cfg_i.step_down};
    if (!cfg_i.pass_mode && now == ltdr_pkg::IN_DIM) begin
      if (light == ltdr_pkg::LS_UP) begin
        if (up_sum < {1'b0, ltdr_pkg::DUTY_ONE}) duty  = up_sum[15:0];
        else                                     light = ltdr_pkg::LS_DOWN;
      end else if (light == ltdr_pkg::LS_DOWN) begin
        if ({1'b0, duty} > down_lim) duty  = duty - cfg_i.step_down;
        else                         light = ltdr_pkg::LS_UP;
      end
    end

    tick_inc = state_i.tick + 16'd1;
    save     = (tick_inc > cfg_i.save_interval);

    state_o.prev_input = now;
    state_o.light      = light;
    state_o.duty       = duty;
    state_o.tick       = save ? 16'd0 : tick_inc;

    result_o.light_state  = light;
    result_o.duty_level   = duty;
    result_o.save_request = save;
    result_o.mapped_input = now;
  end

endmodule

// File: sv/led_toggle_dim_ramp_controller.sv
// Top level of the LED toggle / dim ramp controller.
// Depends on ltdr_pkg, ltdr_in_if, ltdr_out_if, ltdr_cfg_regs and ltdr_step.
//
// Usage:
//   in_i  carries one tick per beat: pulse_class and the current PWM duty.
//   out_o returns exactly one result per tick, in order: light_state,
//         duty_level, save_request and mapped_input.
//   APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds the six
//         registers at byte addresses 0x00..0x14; pready is tied high.
//         Write registers only while no tick is in flight.
// Timing: a tick is captured in an input register and its result is
//   computed by the compare/add logic in ltdr_step into the output
//   register. One tick is accepted every cycle while out_o.ready stays
//   high; the next state from ltdr_step is registered with each result
//   and feeds the next tick directly.
// Stall: when out_o.ready is low the output register holds its result and
//   the input register may still take one more beat; in_i.ready drops only
//   when both are full.
// Reset: rst_ni (async, active low) empties both stages, sets the light off,
//   duty and tick count to zero and loads the register defaults.
module led_toggle_dim_ramp_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  ltdr_in_if.sink                             in_i,
  ltdr_out_if.source                          out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ltdr_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ltdr_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ltdr_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  ltdr_pkg::cfg_t      cfg;
  ltdr_pkg::state_t    state_q, state_d;
  ltdr_pkg::in_item_t  s1_item_q;
  ltdr_pkg::out_item_t out_item_q, out_item_d;
  logic                s1_valid_q;
  logic                out_valid_q;
  logic                advance;
  logic                in_beat;

  ltdr_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ltdr_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (s1_item_q),
    .state_o  (state_d),
    .result_o (out_item_d)
  );

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_beat    = in_i.valid && in_i.ready;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{prev_input: ltdr_pkg::IN_OFF, light: ltdr_pkg::LS_OFF,
                       duty: 16'd0, tick: 16'd0};
    end else begin
      if (in_beat)      s1_valid_q <= 1'b1;
      else if (advance) s1_valid_q <= 1'b0;
      if (advance) out_valid_q <= s1_valid_q;
      if (advance && s1_valid_q) state_q <= state_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_beat) s1_item_q <= in_i.payload;
    if (advance && s1_valid_q) out_item_q <= out_item_d;
  end

endmodule

// File: sv/ltdr_checker.sv
// Port-level checks for the LED toggle / dim ramp controller, bound to the top.
// Depends on ltdr_pkg codes and the top level's port names.
module ltdr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_light,
  input logic [1:0] out_mapped,
  input logic       pready
);

  // the APB side never inserts wait states
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  // input back-pressure only comes from a full, stalled output stage
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output can drain");

  // a stalled result keeps its beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_light)))
    else $error("result changed while stalled");

  // the classifier never yields an unused code
  a_mapped_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_mapped == ltdr_pkg::IN_OFF || out_mapped == ltdr_pkg::IN_ON ||
                   out_mapped == ltdr_pkg::IN_DIM))
    else $error("mapped_input out of range");

endmodule

bind led_toggle_dim_ramp_controller ltdr_checker u_ltdr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_light  (out_o.payload.light_state),
  .out_mapped (out_o.payload.mapped_input),
  .pready     (pready)
);

// File: dv/led_toggle_dim_ramp_controller_test.sv
// Self-checking testbench for led_toggle_dim_ramp_controller: directed and random ticks,
// each result checked against a tick-level predictor of light state, duty and save timing.
// Depends on ltdr_pkg, ltdr_in_if, ltdr_out_if and the block's RTL.
module led_toggle_dim_ramp_controller_test;

  localparam logic [1:0] PC_NONE = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned LATENCY_CYCLES = 4;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ltdr_pkg::CFG_ADDR_W-1:0] paddr;
  logic [ltdr_pkg::CFG_DATA_W-1:0] pwdata;
  logic [ltdr_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  ltdr_in_if  in_if ();
  ltdr_out_if out_if ();

  led_toggle_dim_ramp_controller i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register shadow
  logic        cfg_mode      = 1'b0;
  logic        cfg_map       = 1'b0;
  logic [15:0] cfg_step_up   = ltdr_pkg::STEP_UP_RST;
  logic [15:0] cfg_step_down = ltdr_pkg::STEP_DOWN_RST;
  logic [15:0] cfg_floor     = ltdr_pkg::DUTY_FLOOR_RST;
  logic [15:0] cfg_save_iv   = ltdr_pkg::SAVE_INTERVAL_RST;

  // predicted controller state
  logic [1:0]  prev_class_m = ltdr_pkg::IN_OFF;
  logic [1:0]  light_m      = ltdr_pkg::LS_OFF;
  logic [15:0] duty_m       = '0;
  logic [15:0] tick_m       = '0;

  ltdr_pkg::out_item_t pending_results[$];
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left    = 0;
  bit          idle_en      = 1'b1;

  function automatic ltdr_pkg::out_item_t predict_tick(input ltdr_pkg::in_item_t beat);
    ltdr_pkg::out_item_t res;
    logic [1:0]  cls_now;
    logic [15:0] duty_in;
    logic [16:0] up_sum;
    logic [16:0] down_lim;
    logic        save;
    duty_in = (beat.current_duty > ltdr_pkg::DUTY_ONE) ? ltdr_pkg::DUTY_ONE
                                                        : beat.current_duty;
    if (!cfg_map) begin
      cls_now = (beat.pulse_class == ltdr_pkg::PC_SHORT) ? ltdr_pkg::IN_ON :
                (beat.pulse_class == ltdr_pkg::PC_LONG)  ? ltdr_pkg::IN_DIM :
                                                           ltdr_pkg::IN_OFF;
    end else begin
      cls_now = (beat.pulse_class == ltdr_pkg::PC_HIDDEN) ? ltdr_pkg::IN_ON
                                                          : ltdr_pkg::IN_OFF;
    end
    if (!cfg_mode) begin
      if (cls_now == ltdr_pkg::IN_OFF && prev_class_m == ltdr_pkg::IN_ON) begin
        // a release toggles; from a ramp it always lands on off
        light_m = (light_m == ltdr_pkg::LS_OFF) ? ltdr_pkg::LS_ON : ltdr_pkg::LS_OFF;
      end else if (cls_now == ltdr_pkg::IN_DIM) begin
        if (prev_class_m == ltdr_pkg::IN_ON) begin
          light_m = ltdr_pkg::LS_UP;
          duty_m  = (duty_in < cfg_floor) ? cfg_floor : duty_in;
        end
        up_sum   = {1'b0, duty_m} + {1'b0, cfg_step_up};
        down_lim = {1'b0, cfg_floor} + {1'b0, cfg_step_down};
        if (light_m == ltdr_pkg::LS_UP) begin
          if (up_sum < {1'b0, ltdr_pkg::DUTY_ONE}) duty_m = duty_m + cfg_step_up;
          else light_m = ltdr_pkg::LS_DOWN;
        end else if (light_m == ltdr_pkg::LS_DOWN) begin
          if ({1'b0, duty_m} > down_lim) duty_m = duty_m - cfg_step_down;
          else light_m = ltdr_pkg::LS_UP;
        end
      end
    end else begin
      light_m = (cls_now == ltdr_pkg::IN_OFF) ? ltdr_pkg::LS_ON : ltdr_pkg::LS_OFF;
    end
    prev_class_m = cls_now;
    tick_m = tick_m + 16'd1;
    save = 1'b0;
    if (tick_m > cfg_save_iv) begin
      save   = 1'b1;
      tick_m = '0;
    end
    res.light_state  = light_m;
    res.duty_level   = duty_m;
    res.save_request = save;
    res.mapped_input = cls_now;
    return res;
  endfunction

  // checks on the pre-edge values; compare before push so a result never meets its own tick
  always @(posedge clk_i) begin
    ltdr_pkg::out_item_t want;
    ltdr_pkg::out_item_t got;
    bit        in_beat;
    bit        out_beat;
    if (rst_ni) begin
      in_beat  = in_if.valid && in_if.ready;
      out_beat = out_if.valid && out_if.ready;
      if (out_beat) begin
        got = out_if.payload;
        if (pending_results.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected result: light %0d duty %0d save %0d mapped %0d",
                     got.light_state, got.duty_level, got.save_request, got.mapped_input);
          mismatch_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (got.light_state !== want.light_state || got.duty_level !== want.duty_level ||
              got.save_request !== want.save_request ||
              got.mapped_input !== want.mapped_input) begin
            if (mismatch_cnt < 10)
              $display("result mismatch (exp/got): light %0d/%0d duty %0d/%0d save %0d/%0d %s",
                       want.light_state, got.light_state, want.duty_level, got.duty_level,
                       want.save_request, got.save_request,
                       $sformatf("mapped %0d/%0d", want.mapped_input, got.mapped_input));
            mismatch_cnt++;
          end
        end
      end
      if (in_beat) pending_results.push_back(predict_tick(in_if.payload));
      if (in_beat || out_beat || psel) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // result side: random stall after each beat, none while idle_en is clear
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        hold_left = idle_en ? $urandom_range(0, 8) : 0;
        if (hold_left != 0) out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        if (hold_left == 0) out_if.ready <= 1'b1;
      end else if (!out_if.ready) begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // valid stays high between back-to-back beats
  task automatic send_tick(input logic [1:0] cls, input logic [15:0] duty);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= '{pulse_class: cls, current_duty: duty};
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic wait_results_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      ltdr_pkg::REG_PASS_MODE:     cfg_mode      = val[0];
      ltdr_pkg::REG_INPUT_MAPPING: cfg_map       = val[0];
      ltdr_pkg::REG_STEP_UP:       cfg_step_up   = val;
      ltdr_pkg::REG_STEP_DOWN:     cfg_step_down = val;
      ltdr_pkg::REG_DUTY_FLOOR:    cfg_floor     = val;
      ltdr_pkg::REG_SAVE_INTERVAL: cfg_save_iv   = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic mode, input logic map, input logic [15:0] up,
                            input logic [15:0] down, input logic [15:0] floor_val,
                            input logic [15:0] save_iv);
    cfg_write(ltdr_pkg::REG_PASS_MODE, {15'd0, mode});
    cfg_write(ltdr_pkg::REG_INPUT_MAPPING, {15'd0, map});
    cfg_write(ltdr_pkg::REG_STEP_UP, up);
    cfg_write(ltdr_pkg::REG_STEP_DOWN, down);
    cfg_write(ltdr_pkg::REG_DUTY_FLOOR, floor_val);
    cfg_write(ltdr_pkg::REG_SAVE_INTERVAL, save_iv);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly in range, now and then above full scale
  function automatic logic [15:0] rand_duty();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 32768));
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 3))
      0: return 16'd1;
      1: return ltdr_pkg::DUTY_ONE;
      2: return 16'($urandom_range(1, 2000));
      default: return 16'($urandom_range(1, 32768));
    endcase
  endfunction

  // reset defaults; "none" class counts as off
  task automatic test_toggle_defaults();
    send_tick(ltdr_pkg::PC_SHORT, 16'd0);
    send_tick(ltdr_pkg::PC_HIDDEN, 16'hFFFF);
    send_tick(ltdr_pkg::PC_SHORT, ltdr_pkg::DUTY_ONE);
    send_tick(PC_NONE, 16'd1);
    wait_results_idle();
  endtask

  // ramp turnaround, clamp of duty above one, raise to floor, toggle out of a ramp,
  // dim with no press before it
  task automatic test_dim_ramp();
    set_config(1'b0, 1'b0, 16'd16384, 16'd16384, 16'd8000, 16'd30000);
    send_tick(ltdr_pkg::PC_SHORT, 16'd0);
    send_tick(ltdr_pkg::PC_LONG, 16'hFFFF);
    repeat (3) send_tick(ltdr_pkg::PC_LONG, rand_duty());
    send_tick(ltdr_pkg::PC_SHORT, 16'd0);
    send_tick(ltdr_pkg::PC_LONG, 16'd100);
    send_tick(ltdr_pkg::PC_HIDDEN, 16'd0);
    send_tick(ltdr_pkg::PC_LONG, 16'd0);
    send_tick(ltdr_pkg::PC_SHORT, 16'd0);
    send_tick(ltdr_pkg::PC_HIDDEN, 16'd0);
    send_tick(ltdr_pkg::PC_LONG, 16'd0);
    wait_results_idle();
  endtask

  task automatic test_mapping_one();
    set_config(1'b0, 1'b1, ltdr_pkg::STEP_UP_RST, ltdr_pkg::STEP_DOWN_RST,
               ltdr_pkg::DUTY_FLOOR_RST, ltdr_pkg::SAVE_INTERVAL_RST);
    send_tick(ltdr_pkg::PC_HIDDEN, rand_duty());
    send_tick(ltdr_pkg::PC_LONG, rand_duty());
    send_tick(PC_NONE, rand_duty());
    wait_results_idle();
  endtask

  // pass mode, dim input gives off; interval at all ones never saves
  task automatic test_pass_mode();
    set_config(1'b1, 1'b0, ltdr_pkg::STEP_UP_RST, ltdr_pkg::STEP_DOWN_RST,
               ltdr_pkg::DUTY_FLOOR_RST, 16'hFFFF);
    send_tick(ltdr_pkg::PC_HIDDEN, rand_duty());
    send_tick(ltdr_pkg::PC_SHORT, rand_duty());
    send_tick(ltdr_pkg::PC_LONG, rand_duty());
    send_tick(PC_NONE, rand_duty());
    wait_results_idle();
  endtask

  // floor above one with zero steps: ramp flips direction every tick; save every other tick
  task automatic test_odd_ramp();
    set_config(1'b0, 1'b0, 16'd0, 16'd0, 16'hFFFF, 16'd1);
    send_tick(ltdr_pkg::PC_SHORT, rand_duty());
    repeat (3) send_tick(ltdr_pkg::PC_LONG, rand_duty());
    wait_results_idle();
  endtask

  task automatic test_random_phases();
    int unsigned sent;
    int unsigned run;
    logic [1:0]  cls;
    for (int phase = 0; phase < 8; phase++) begin
      idle_en = !(phase == 2 || phase == 5);
      if (phase == 0) begin
        set_config(1'b0, 1'b0, 16'd1, 16'd1, 16'd0, 16'd1);
      end else if (phase == 7) begin
        set_config(1'b0, 1'b0, ltdr_pkg::DUTY_ONE, ltdr_pkg::DUTY_ONE, ltdr_pkg::DUTY_ONE,
                   16'd65534);
      end else begin
        set_config($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, pick_step(),
                   pick_step(),
                   $urandom_range(0, 1) ? 16'($urandom_range(0, 8000))
                                        : 16'($urandom_range(0, 32768)),
                   $urandom_range(0, 1) ? 16'($urandom_range(1, 300))
                                        : 16'($urandom_range(1, 65534)));
      end
      sent = 0;
      while (sent < 75) begin
        if ($urandom_range(0, 2) != 0) begin
          // press, then hold dim for a while
          run = $urandom_range(1, 2);
          repeat (run) send_tick(ltdr_pkg::PC_SHORT, rand_duty());
          sent += run;
          run = $urandom_range(1, 60);
          repeat (run) send_tick(ltdr_pkg::PC_LONG, rand_duty());
          sent += run;
        end else begin
          cls = 2'($urandom_range(0, 3));
          run = $urandom_range(1, 4);
          repeat (run) send_tick(cls, rand_duty());
          sent += run;
        end
      end
      wait_results_idle();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    out_if.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_toggle_defaults();
    test_dim_ramp();
    test_mapping_one();
    test_pass_mode();
    test_odd_ramp();
    test_random_phases();
    wait_results_idle();
    repeat (LATENCY_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
sv/ltdr_pkg.sv
sv/ltdr_in_if.sv
sv/ltdr_out_if.sv
sv/ltdr_cfg_regs.sv
sv/ltdr_step.sv
sv/led_toggle_dim_ramp_controller.sv
sv/ltdr_checker.sv
dv/led_toggle_dim_ramp_controller_test.sv
